// ----- design/assert_macros.svh -----
// Assertion helper macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock, disabled in reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- design/gwgc_pkg.sv -----
// ----------------------------------------------------------------------------
// gwgc_pkg
// Shared widths, constants and types for the gyro to cursor pipeline.
// ----------------------------------------------------------------------------
package gwgc_pkg;
  localparam int FRAC_BITS = 8;
  localparam int OUT_W     = 21;
  // numerator magnitude: |s| < 3*2^30*2^15 -> 47 bits; scale < 2^(16+3+FRAC)
  localparam int SCALE_W   = 16 + 3 + FRAC_BITS;
  localparam int MAG_W     = 47;
  localparam int PROD_W    = MAG_W + SCALE_W;
  localparam int WSUM_W    = 32;
  localparam int DEN_W     = WSUM_W + 23;
  localparam logic [22:0] DEN_SCALE = 23'd8192000;
  // quotient bits kept: values above 2^22 all saturate
  localparam int Q_W       = 23;
  localparam int NCELL     = Q_W;

  localparam logic [0:0] REG_USE_ACCEL  = 1'b0;
  localparam logic [0:0] REG_GYRO_RANGE = 1'b1;

  typedef struct packed {
    logic              neg;
    logic              zero;
    logic [DEN_W-1:0]  den;
    logic [PROD_W-1:0] rem;
    logic [Q_W-1:0]    q;
  } div_lane_t;

  typedef struct packed {
    logic      valid;
    div_lane_t yaw;
    div_lane_t pitch;
  } cell_data_t;
endpackage

// ----- design/gwgc_front.sv -----
// ----------------------------------------------------------------------------
// gwgc_front
// Signs, squares and weighted sums; builds dividend and divisor per lane.
// Five register stages: squares, weighted products, sums and magnitudes,
// scale multiply halves, dividend and divisor.
// ----------------------------------------------------------------------------
module gwgc_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [111:0]            in_data,
  input  logic                    use_accel,
  input  logic [1:0]              gyro_range,
  output gwgc_pkg::cell_data_t    out
);
  import gwgc_pkg::*;

  logic signed [15:0] ax, ay, az, gx, gy, gz;
  logic [15:0] us;
  logic signed [16:0] sx, sy, sz;
  assign ax = in_data[15:0];
  assign ay = in_data[31:16];
  assign az = in_data[47:32];
  assign gx = in_data[63:48];
  assign gy = in_data[79:64];
  assign gz = in_data[95:80];
  assign us = in_data[111:96];
  assign sx = ax[15] ? -17'(gx) : 17'(gx);
  assign sy = ay[15] ? -17'(gy) : 17'(gy);
  assign sz = az[15] ? -17'(gz) : 17'(gz);

  // stage 1
  logic v1, ua1;
  logic [30:0] ax2, ay2, az2;
  logic signed [16:0] sx1, sy1, sz1, gy1, gz1;
  logic [SCALE_W-1:0] sc1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
    if (en) begin
      ax2 <= 31'(32'(ax * ax));
      ay2 <= 31'(32'(ay * ay));
      az2 <= 31'(32'(az * az));
      sx1 <= sx; sy1 <= sy; sz1 <= sz;
      gy1 <= 17'(gy); gz1 <= 17'(gz);
      ua1 <= use_accel;
      sc1 <= SCALE_W'({11'd0, us} << gyro_range) << FRAC_BITS;
    end
  end

  // stage 2: weighted products
  logic v2, ua2;
  logic signed [48:0] px, py, pz, qy, qz;
  logic [WSUM_W-1:0] n2, m2;
  logic signed [16:0] gy2, gz2;
  logic [SCALE_W-1:0] sc2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
    if (en) begin
      px <= 49'($signed({1'b0, ax2}) * sx1);
      py <= 49'($signed({1'b0, ay2}) * sy1);
      pz <= 49'($signed({1'b0, az2}) * sz1);
      qy <= 49'($signed({1'b0, az2}) * sy1);
      qz <= 49'($signed({1'b0, ay2}) * sz1);
      n2 <= 32'(ay2) + 32'(az2);
      m2 <= 32'(ax2) + 32'(ay2) + 32'(az2);
      gy2 <= gy1; gz2 <= gz1; ua2 <= ua1; sc2 <= sc1;
    end
  end

  // stage 3: sums, magnitudes
  logic v3;
  logic [MAG_W-1:0] my3, mp3;
  logic ny3, np3;
  logic [WSUM_W-1:0] wy3, wp3;
  logic [SCALE_W-1:0] sc3;
  logic signed [48:0] ys, ps;
  always_comb begin
    if (ua2) begin
      ys = px + py + pz;
      ps = qy + qz;
    end else begin
      ys = 49'(gz2);
      ps = 49'(gy2);
    end
  end
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
    if (en) begin
      ny3 <= ys[48];
      np3 <= ps[48];
      my3 <= MAG_W'(ys[48] ? -ys : ys);
      mp3 <= MAG_W'(ps[48] ? -ps : ps);
      wy3 <= ua2 ? m2 : 32'd1;
      wp3 <= ua2 ? n2 : 32'd1;
      sc3 <= sc2;
    end
  end

  // stage 4: partial products of magnitude x scale (split in halves)
  logic v4;
  logic ny4, np4;
  logic [WSUM_W-1:0] wy4, wp4;
  logic [PROD_W-1:0] yl4, yh4, pl4, ph4;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
    if (en) begin
      ny4 <= ny3; np4 <= np3; wy4 <= wy3; wp4 <= wp3;
      yl4 <= PROD_W'(my3[23:0] * sc3);
      yh4 <= PROD_W'(my3[MAG_W-1:24] * sc3);
      pl4 <= PROD_W'(mp3[23:0] * sc3);
      ph4 <= PROD_W'(mp3[MAG_W-1:24] * sc3);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out.valid <= 1'b0;
    else if (en) out.valid <= v4;
    if (en) begin
      out.yaw.neg   <= ny4;
      out.yaw.zero  <= (wy4 == '0);
      out.yaw.den   <= DEN_W'(DEN_SCALE * wy4);
      out.yaw.rem   <= yl4 + (yh4 << 24);
      out.yaw.q     <= '0;
      out.pitch.neg  <= np4;
      out.pitch.zero <= (wp4 == '0);
      out.pitch.den  <= DEN_W'(DEN_SCALE * wp4);
      out.pitch.rem  <= pl4 + (ph4 << 24);
      out.pitch.q    <= '0;
    end
  end
endmodule

// ----- design/gwgc_cell.sv -----
// ----------------------------------------------------------------------------
// gwgc_cell
// One restoring-division step per lane for a given quotient bit position.
// ----------------------------------------------------------------------------
module gwgc_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic [4:0]           bitpos,
  input  gwgc_pkg::cell_data_t din,
  output gwgc_pkg::cell_data_t dout
);
  import gwgc_pkg::*;

  function automatic div_lane_t step(div_lane_t l, logic [4:0] b);
    logic [PROD_W+Q_W-1:0] d;
    div_lane_t r;
    d = (PROD_W+Q_W)'(l.den) << b;
    r = l;
    if (l.zero == 1'b0 && (PROD_W+Q_W)'(l.rem) >= d) begin
      r.rem = PROD_W'((PROD_W+Q_W)'(l.rem) - d);
      r.q[b] = 1'b1;
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) dout.valid <= 1'b0;
    else if (en) dout.valid <= din.valid;
    if (en) begin
      dout.yaw   <= step(din.yaw, bitpos);
      dout.pitch <= step(din.pitch, bitpos);
    end
  end
endmodule

// ----- design/gravity_weighted_gyro_to_cursor.sv -----
// ----------------------------------------------------------------------------
// gravity_weighted_gyro_to_cursor
// Gyro sample to cursor yaw/pitch deltas, pipelined division chain.
// ----------------------------------------------------------------------------
// Accepts one sample per cycle unless the output stalls. The path is five
// front stages, a chain of 23 division cells, one per quotient bit, and the
// output register. The whole pipeline advances whenever the output register
// is empty or being taken, one transfer per clock. Quotients at or above
// 2^23 are not resolved; they saturate to the 21-bit range.
module gravity_weighted_gyro_to_cursor (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [111:0] s_axis_tdata,  // accel_x,y,z, gyro_x,y,z, interval_us
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [47:0]  m_axis_tdata,  // yaw_delta[20:0], pitch_delta[20:0], pad
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [0:0]   cfg_index,
  input  logic [1:0]   cfg_data
);
  import gwgc_pkg::*;

  logic use_accel;
  logic [1:0] gyro_range;
  logic en;
  cell_data_t chain [NCELL+1];

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      use_accel  <= 1'b1;
      gyro_range <= 2'd0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_USE_ACCEL) use_accel <= cfg_data[0];
      if (cfg_index == REG_GYRO_RANGE) gyro_range <= cfg_data;
    end
  end

  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  gwgc_front u_front (
    .clk, .rst, .en,
    .in_valid(s_axis_tvalid),
    .in_data(s_axis_tdata),
    .use_accel, .gyro_range,
    .out(chain[0])
  );

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    gwgc_cell u_cell (
      .clk, .rst, .en,
      .bitpos(5'(NCELL - 1 - i)),
      .din(chain[i]),
      .dout(chain[i+1])
    );
  end

  function automatic logic [OUT_W-1:0] sat(div_lane_t l);
    logic [Q_W-1:0] q;
    q = l.zero ? '0 : l.q;
    if (l.neg) begin
      if (q > Q_W'(1 << (OUT_W-1))) q = Q_W'(1 << (OUT_W-1));
      return OUT_W'(-q);
    end
    if (q > Q_W'((1 << (OUT_W-1)) - 1)) q = Q_W'((1 << (OUT_W-1)) - 1);
    return OUT_W'(q);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (en) m_axis_tvalid <= chain[NCELL].valid;
    if (en)
      m_axis_tdata <= {6'd0, sat(chain[NCELL].pitch), sat(chain[NCELL].yaw)};
  end
endmodule

// ----- design/gwgc_checker.sv -----
// ----------------------------------------------------------------------------
// gwgc_checker
// Port-level checks on the cursor block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module gwgc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);
  `ASSERT_NEXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
  `ASSERT_NEXT(a_vhold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `ASSERT_IMPL(a_ready, clk, rst, !m_axis_tvalid, s_axis_tready)
  `ASSERT_IMPL(a_pad, clk, rst, m_axis_tvalid, m_axis_tdata[47:42] == 6'd0)
endmodule

bind gravity_weighted_gyro_to_cursor gwgc_checker u_chk (
  .clk, .rst, .s_axis_tready, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
